// ===== src/ftp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftp_pkg
// Shared constants, codes and types of the token pool with its wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ftp_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_BITS  = 32;
   localparam int HANDLE_BITS = 16;
   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 3;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [OP_BITS-1:0] OP_REQUEST     = OP_BITS'(0);
   localparam logic [OP_BITS-1:0] OP_RELEASE     = OP_BITS'(1);
   localparam logic [OP_BITS-1:0] OP_ADD_LIMIT   = OP_BITS'(2);
   localparam logic [OP_BITS-1:0] OP_CANCEL      = OP_BITS'(3);
   localparam logic [OP_BITS-1:0] OP_TRY_REQUEST = OP_BITS'(4);

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_GRANTED   = STATUS_BITS'(0);
   localparam logic [STATUS_BITS-1:0] ST_QUEUED    = STATUS_BITS'(1);
   localparam logic [STATUS_BITS-1:0] ST_REFUSED   = STATUS_BITS'(2);
   localparam logic [STATUS_BITS-1:0] ST_CANCELLED = STATUS_BITS'(3);
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = STATUS_BITS'(4);
   localparam logic [STATUS_BITS-1:0] ST_FULL      = STATUS_BITS'(5);
   localparam logic [STATUS_BITS-1:0] ST_DONE      = STATUS_BITS'(6);

   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [PTR_BITS-1:0] addr;
      entry_type           data;
   } ram_wr_type;

   typedef struct packed {
      logic                  sub;
      logic [COUNT_BITS-1:0] lhs;
      logic [COUNT_BITS-1:0] rhs;
   } alu_cmd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] value;
      logic                  carry;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== src/ftp_alu.sv =====
// ----------------------------------------------------------------------------
// ftp_alu
// Shared add/subtract unit; carry out flags overflow on add, no borrow on sub.
// ----------------------------------------------------------------------------
`default_nettype none

module ftp_alu
   import ftp_pkg::*;
(
   input  wire alu_cmd_type cmd,
   output alu_res_type      res
);

   logic [COUNT_BITS:0] sum;

   assign sum = {1'b0, cmd.lhs} + {1'b0, cmd.rhs ^ {COUNT_BITS{cmd.sub}}}
              + {{COUNT_BITS{1'b0}}, cmd.sub};

   assign res.value = sum[COUNT_BITS-1:0];
   assign res.carry = sum[COUNT_BITS];

endmodule

`default_nettype wire

// ===== src/ftp_ram.sv =====
// ----------------------------------------------------------------------------
// ftp_ram
// Wait queue storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ftp_ram
   import ftp_pkg::*;
(
   input  wire logic                clock,
   input  wire ram_wr_type          wr,
   input  wire logic [PTR_BITS-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/fifo_token_pool_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_token_pool_unit
// Counting token pool with a first-in first-out wait queue, run by a small
// sequencer around one shared add/subtract unit and a queue memory.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  operation, count, limit, handle
//   rsp      out        rsp_valid / rsp_stall  status, handles, woke, tokens
//   csr      in         csr_write_en           csr_write_data (initial tokens)
//
// accept to response: request, try request, unknown go from exec to done; release
// sums and reads the head, granting it if waiting and its count fits; add ends at
// once for a zero count or at or over a nonzero limit, else adds the count, clamped
// to room under a nonzero limit, and wakes like release; cancel reads and compares
// each entry searched, then reads and writes each moved down; req_stall until idle
// reset empties the queue and sets the pool to zero tokens; no clearing pass
// a new transaction is taken while a finished result still waits on rsp_stall
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_token_pool_unit
   import ftp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [OP_BITS-1:0]     req_operation,
   input  wire logic [COUNT_BITS-1:0]  req_count,
   input  wire logic [COUNT_BITS-1:0]  req_limit,
   input  wire logic [HANDLE_BITS-1:0] req_handle,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [STATUS_BITS-1:0] rsp_status,
   output      logic [HANDLE_BITS-1:0] rsp_assigned_handle,
   output      logic                   rsp_woke_waiter,
   output      logic [HANDLE_BITS-1:0] rsp_woken_handle,
   output      logic [COUNT_BITS-1:0]  rsp_tokens_free,
   input  wire logic                   csr_write_en,
   input  wire logic [COUNT_BITS-1:0]  csr_write_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_ADD_CHK  = 4'd2;
   localparam logic [3:0] S_ADD_ROOM = 4'd3;
   localparam logic [3:0] S_ADD_MIN  = 4'd4;
   localparam logic [3:0] S_SUM      = 4'd5;
   localparam logic [3:0] S_WAKE_RD  = 4'd6;
   localparam logic [3:0] S_WAKE_CMP = 4'd7;
   localparam logic [3:0] S_CAN_RD   = 4'd8;
   localparam logic [3:0] S_CAN_CMP  = 4'd9;
   localparam logic [3:0] S_MV_RD    = 4'd10;
   localparam logic [3:0] S_MV_WR    = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] base,
                                                   input logic [PTR_BITS-1:0] off);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_BITS+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_BITS+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   logic [3:0]             state_ff, state_in;
   logic [COUNT_BITS-1:0]  free_ff, free_in;
   logic [OCC_BITS-1:0]    occ_ff, occ_in;
   logic [PTR_BITS-1:0]    head_ff, head_in;
   logic [HANDLE_BITS-1:0] next_handle_ff, next_handle_in;
   logic [OCC_BITS-1:0]    idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  tmp_ff, tmp_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  limit_ff, limit_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0] assigned_ff, assigned_in;
   logic                   woke_ff, woke_in;
   logic [HANDLE_BITS-1:0] woken_ff, woken_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_assigned_ff, rsp_assigned_in;
   logic                   rsp_woke_ff, rsp_woke_in;
   logic [HANDLE_BITS-1:0] rsp_woken_ff, rsp_woken_in;
   logic [COUNT_BITS-1:0]  rsp_tokens_ff, rsp_tokens_in;

   alu_cmd_type            alu_cmd;
   alu_res_type            alu_res;
   ram_wr_type             ram_wr;
   logic [PTR_BITS-1:0]    ram_rd_addr;
   entry_type              ram_rd_data;
   logic [OCC_BITS-1:0]    idx_next;
   logic                   mv_last;

   ftp_alu u_alu (
      .cmd (alu_cmd),
      .res (alu_res)
   );

   ftp_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign idx_next  = idx_ff + OCC_BITS'(1);
   assign mv_last   = (idx_next == occ_ff);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      free_in         = free_ff;
      occ_in          = occ_ff;
      head_in         = head_ff;
      next_handle_in  = next_handle_ff;
      idx_in          = idx_ff;
      tmp_in          = tmp_ff;
      op_in           = op_ff;
      count_in        = count_ff;
      limit_in        = limit_ff;
      handle_in       = handle_ff;
      status_in       = status_ff;
      assigned_in     = assigned_ff;
      woke_in         = woke_ff;
      woken_in        = woken_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_woke_in     = rsp_woke_ff;
      rsp_woken_in    = rsp_woken_ff;
      rsp_tokens_in   = rsp_tokens_ff;
      alu_cmd         = '{sub: 1'b1, lhs: free_ff, rhs: count_ff};
      ram_rd_addr     = head_ff;
      ram_wr          = '{en: 1'b0,
                          addr: ptr_add(head_ff, occ_ff[PTR_BITS-1:0]),
                          data: '{count: count_ff, handle: next_handle_ff}};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_operation;
               count_in    = req_count;
               limit_in    = req_limit;
               handle_in   = req_handle;
               assigned_in = '0;
               woke_in     = 1'b0;
               woken_in    = '0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff) inside
               OP_REQUEST, OP_TRY_REQUEST: begin
                  state_in = S_DONE;
                  if (count_ff == '0) begin
                     status_in = ST_GRANTED;
                  end else if (occ_ff == '0 && alu_res.carry) begin
                     free_in   = alu_res.value;
                     status_in = ST_GRANTED;
                  end else if (op_ff == OP_TRY_REQUEST) begin
                     status_in = ST_REFUSED;
                  end else if (occ_ff == OCC_BITS'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_wr.en      = 1'b1;
                     occ_in         = occ_ff + OCC_BITS'(1);
                     assigned_in    = next_handle_ff;
                     next_handle_in = (next_handle_ff == '1) ? HANDLE_BITS'(1)
                                                             : next_handle_ff + HANDLE_BITS'(1);
                     status_in      = ST_QUEUED;
                  end
               end
               OP_RELEASE: begin
                  status_in = ST_DONE;
                  tmp_in    = count_ff;
                  state_in  = S_SUM;
               end
               OP_ADD_LIMIT: begin
                  status_in = ST_DONE;
                  if (count_ff == '0) begin
                     state_in = S_DONE;
                  end else if (limit_ff == '0) begin
                     tmp_in   = count_ff;
                     state_in = S_SUM;
                  end else begin
                     state_in = S_ADD_CHK;
                  end
               end
               OP_CANCEL: begin
                  status_in = ST_NOT_FOUND;
                  idx_in    = '0;
                  state_in  = S_CAN_RD;
               end
               default: begin
                  status_in = ST_REFUSED;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_ADD_CHK: begin
            alu_cmd  = '{sub: 1'b1, lhs: free_ff, rhs: limit_ff};
            state_in = alu_res.carry ? S_DONE : S_ADD_ROOM;
         end
         S_ADD_ROOM: begin
            alu_cmd  = '{sub: 1'b1, lhs: limit_ff, rhs: free_ff};
            tmp_in   = alu_res.value;
            state_in = S_ADD_MIN;
         end
         S_ADD_MIN: begin
            alu_cmd = '{sub: 1'b1, lhs: tmp_ff, rhs: count_ff};
            if (alu_res.carry) begin
               tmp_in = count_ff;
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            alu_cmd  = '{sub: 1'b0, lhs: free_ff, rhs: tmp_ff};
            free_in  = alu_res.carry ? '1 : alu_res.value;
            state_in = S_WAKE_RD;
         end
         S_WAKE_RD: begin
            state_in = (occ_ff == '0) ? S_DONE : S_WAKE_CMP;
         end
         S_WAKE_CMP: begin
            alu_cmd = '{sub: 1'b1, lhs: free_ff, rhs: ram_rd_data.count};
            if (alu_res.carry) begin
               free_in  = alu_res.value;
               head_in  = ptr_add(head_ff, PTR_BITS'(1));
               occ_in   = occ_ff - OCC_BITS'(1);
               woke_in  = 1'b1;
               woken_in = ram_rd_data.handle;
            end
            state_in = S_DONE;
         end
         S_CAN_RD: begin
            ram_rd_addr = ptr_add(head_ff, idx_ff[PTR_BITS-1:0]);
            state_in    = (idx_ff == occ_ff) ? S_DONE : S_CAN_CMP;
         end
         S_CAN_CMP: begin
            if (ram_rd_data.handle == handle_ff) begin
               status_in = ST_CANCELLED;
               state_in  = S_MV_RD;
            end else begin
               idx_in   = idx_next;
               state_in = S_CAN_RD;
            end
         end
         S_MV_RD: begin
            ram_rd_addr = ptr_add(head_ff, idx_next[PTR_BITS-1:0]);
            if (mv_last) begin
               occ_in   = occ_ff - OCC_BITS'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = ptr_add(head_ff, idx_ff[PTR_BITS-1:0]);
            ram_wr.data = ram_rd_data;
            idx_in      = idx_next;
            state_in    = S_MV_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_assigned_in = assigned_ff;
               rsp_woke_in     = woke_ff;
               rsp_woken_in    = woken_ff;
               rsp_tokens_in   = free_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_en) begin
         free_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         free_ff        <= '0;
         occ_ff         <= '0;
         head_ff        <= '0;
         next_handle_ff <= HANDLE_BITS'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_ff        <= free_in;
         occ_ff         <= occ_in;
         head_ff        <= head_in;
         next_handle_ff <= next_handle_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      tmp_ff          <= tmp_in;
      op_ff           <= op_in;
      count_ff        <= count_in;
      limit_ff        <= limit_in;
      handle_ff       <= handle_in;
      status_ff       <= status_in;
      assigned_ff     <= assigned_in;
      woke_ff         <= woke_in;
      woken_ff        <= woken_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_woke_ff     <= rsp_woke_in;
      rsp_woken_ff    <= rsp_woken_in;
      rsp_tokens_ff   <= rsp_tokens_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_assigned_handle = rsp_assigned_ff;
   assign rsp_woke_waiter     = rsp_woke_ff;
   assign rsp_woken_handle    = rsp_woken_ff;
   assign rsp_tokens_free     = rsp_tokens_ff;

   // queue occupancy never exceeds its depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(QUEUE_DEPTH))
      else $error("wait queue occupancy over depth");

   // queuing a request grows the queue by one
   a_enqueue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && ram_wr.en) |=> occ_ff == $past(occ_ff) + OCC_BITS'(1))
      else $error("enqueue did not grow the queue");

   // granting the head waiter shrinks the queue by one
   a_wake: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE_CMP && alu_res.carry) |=> occ_ff == $past(occ_ff) - OCC_BITS'(1))
      else $error("wake did not shrink the queue");

   // a response only appears out of the completion step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");

endmodule

`default_nettype wire

// ===== tb/pool_checker.sv =====
// ----------------------------------------------------------------------------
// pool_checker
// Watches the request, response and csr ports of the token pool, keeps its
// own copy of the pool and the wait queue, predicts one response per request
// transaction and compares every response field by field, in order.
// ----------------------------------------------------------------------------
module pool_checker
   import ftp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [OP_BITS-1:0]     req_operation,
   input  wire logic [COUNT_BITS-1:0]  req_count,
   input  wire logic [COUNT_BITS-1:0]  req_limit,
   input  wire logic [HANDLE_BITS-1:0] req_handle,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [STATUS_BITS-1:0] rsp_status,
   input  wire logic [HANDLE_BITS-1:0] rsp_assigned_handle,
   input  wire logic                   rsp_woke_waiter,
   input  wire logic [HANDLE_BITS-1:0] rsp_woken_handle,
   input  wire logic [COUNT_BITS-1:0]  rsp_tokens_free,
   input  wire logic                   csr_write_en,
   input  wire logic [COUNT_BITS-1:0]  csr_write_data,
   output int                          mismatches,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [HANDLE_BITS-1:0] assigned_handle;
      logic                   woke_waiter;
      logic [HANDLE_BITS-1:0] woken_handle;
      logic [COUNT_BITS-1:0]  tokens_free;
   } pool_reply_type;

   localparam logic [COUNT_BITS-1:0]  POOL_MAX   = '1;
   localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

   logic [COUNT_BITS-1:0]  pool_free;
   logic [COUNT_BITS-1:0]  waiter_count[$];
   logic [HANDLE_BITS-1:0] waiter_handle[$];
   logic [HANDLE_BITS-1:0] handle_next;
   pool_reply_type         expected_replies[$];
   int                     fail_total;

   function automatic logic [COUNT_BITS-1:0] saturating_add(
      input logic [COUNT_BITS-1:0] a,
      input logic [COUNT_BITS-1:0] b
   );
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_BITS] ? POOL_MAX : sum[COUNT_BITS-1:0];
   endfunction

   // grant the head waiter if its count fits, 0 when nobody is woken
   function automatic logic [HANDLE_BITS-1:0] grant_head();
      logic [HANDLE_BITS-1:0] granted;
      if (waiter_count.size() == 0 || waiter_count[0] > pool_free)
         return '0;
      pool_free = pool_free - waiter_count[0];
      granted   = waiter_handle[0];
      waiter_count.delete(0);
      waiter_handle.delete(0);
      return granted;
   endfunction

   function automatic pool_reply_type predict_reply(
      input logic [OP_BITS-1:0]     op,
      input logic [COUNT_BITS-1:0]  count,
      input logic [COUNT_BITS-1:0]  limit,
      input logic [HANDLE_BITS-1:0] handle
   );
      pool_reply_type         r;
      logic [HANDLE_BITS-1:0] woken;
      logic [COUNT_BITS-1:0]  room;
      r.status          = ST_REFUSED;
      r.assigned_handle = '0;
      woken             = '0;
      case (op)
         OP_REQUEST, OP_TRY_REQUEST: begin
            if (count == '0) begin
               r.status = ST_GRANTED;
            end else if (waiter_count.size() == 0 && pool_free >= count) begin
               pool_free = pool_free - count;
               r.status  = ST_GRANTED;
            end else if (op == OP_TRY_REQUEST) begin
               r.status = ST_REFUSED;
            end else if (waiter_count.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               waiter_count.insert(waiter_count.size(), count);
               waiter_handle.insert(waiter_handle.size(), handle_next);
               r.assigned_handle = handle_next;
               handle_next = (handle_next == HANDLE_MAX) ? HANDLE_BITS'(1)
                                                         : handle_next + HANDLE_BITS'(1);
               r.status = ST_QUEUED;
            end
         end
         OP_RELEASE: begin
            pool_free = saturating_add(pool_free, count);
            woken     = grant_head();
            r.status  = ST_DONE;
         end
         OP_ADD_LIMIT: begin
            r.status = ST_DONE;
            if (count != '0 && (limit == '0 || pool_free < limit)) begin
               if (limit != '0) begin
                  room      = limit - pool_free;
                  pool_free = saturating_add(pool_free, (room < count) ? room : count);
               end else begin
                  pool_free = saturating_add(pool_free, count);
               end
               woken = grant_head();
            end
         end
         OP_CANCEL: begin
            r.status = ST_NOT_FOUND;
            foreach (waiter_handle[i]) begin
               if (r.status == ST_NOT_FOUND && waiter_handle[i] == handle) begin
                  waiter_count.delete(i);
                  waiter_handle.delete(i);
                  r.status = ST_CANCELLED;
                  break;
               end
            end
         end
         default: r.status = ST_REFUSED;
      endcase
      r.woke_waiter  = (woken != '0);
      r.woken_handle = woken;
      r.tokens_free  = pool_free;
      return r;
   endfunction

   function automatic int field_differs(
      input string                 name,
      input logic [COUNT_BITS-1:0] want,
      input logic [COUNT_BITS-1:0] got
   );
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      pool_reply_type want;
      int             delta;
      int             bad;
      if (reset) begin
         pool_free   = '0;
         handle_next = HANDLE_BITS'(1);
         waiter_count.delete();
         waiter_handle.delete();
         expected_replies.delete();
         fail_total  = 0;
         outstanding <= 0;
         mismatches  <= 0;
      end else begin
         delta = 0;
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("response transaction with no request waiting for it");
               fail_total++;
            end else begin
               want = expected_replies[0];
               expected_replies.delete(0);
               bad  = field_differs("status", COUNT_BITS'(want.status),
                                    COUNT_BITS'(rsp_status));
               bad += field_differs("assigned_handle", COUNT_BITS'(want.assigned_handle),
                                    COUNT_BITS'(rsp_assigned_handle));
               bad += field_differs("woke_waiter", COUNT_BITS'(want.woke_waiter),
                                    COUNT_BITS'(rsp_woke_waiter));
               bad += field_differs("woken_handle", COUNT_BITS'(want.woken_handle),
                                    COUNT_BITS'(rsp_woken_handle));
               bad += field_differs("tokens_free", want.tokens_free, rsp_tokens_free);
               if (bad != 0)
                  fail_total++;
               delta--;
            end
         end
         if (csr_write_en)
            pool_free = csr_write_data;
         if (req_valid && !req_stall) begin
            expected_replies.insert(expected_replies.size(),
                                    predict_reply(req_operation, req_count,
                                                  req_limit, req_handle));
            delta++;
         end
         outstanding <= outstanding + delta;
         mismatches  <= fail_total;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the token pool with a directed pass over its corner cases, a full
// wait queue with cancels at its head, middle and tail, and random
// transactions under several initial token settings, with random idles on
// both channels.
// ----------------------------------------------------------------------------
module testbench
   import ftp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_BITS-1:0]    OP_UNKNOWN_LO = OP_TRY_REQUEST + 1'b1;
   localparam logic [OP_BITS-1:0]    OP_UNKNOWN_HI = '1;
   localparam logic [COUNT_BITS-1:0] ALL_ONES      = '1;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic [OP_BITS-1:0]     req_operation  = OP_REQUEST;
   logic [COUNT_BITS-1:0]  req_count      = '0;
   logic [COUNT_BITS-1:0]  req_limit      = '0;
   logic [HANDLE_BITS-1:0] req_handle     = '0;
   logic                   rsp_stall      = 1'b0;
   logic                   csr_write_en   = 1'b0;
   logic [COUNT_BITS-1:0]  csr_write_data = '0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [HANDLE_BITS-1:0] rsp_assigned_handle;
   logic                   rsp_woke_waiter;
   logic [HANDLE_BITS-1:0] rsp_woken_handle;
   logic [COUNT_BITS-1:0]  rsp_tokens_free;

   int                     fail_total;
   int                     replies_due;
   int                     stall_left = 0;
   bit                     calm       = 1'b1;
   logic [HANDLE_BITS-1:0] recent_handles[$];

   fifo_token_pool_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_count           (req_count),
      .req_limit           (req_limit),
      .req_handle          (req_handle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_assigned_handle (rsp_assigned_handle),
      .rsp_woke_waiter     (rsp_woke_waiter),
      .rsp_woken_handle    (rsp_woken_handle),
      .rsp_tokens_free     (rsp_tokens_free),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data)
   );

   pool_checker pool_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_count           (req_count),
      .req_limit           (req_limit),
      .req_handle          (req_handle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_assigned_handle (rsp_assigned_handle),
      .rsp_woke_waiter     (rsp_woke_waiter),
      .rsp_woken_handle    (rsp_woken_handle),
      .rsp_tokens_free     (rsp_tokens_free),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .mismatches          (fail_total),
      .outstanding         (replies_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #120_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // response side backpressure, also remembers handles for cancels
   always @(posedge clock) begin
      int draw;
      if (rsp_valid && !rsp_stall) begin
         if (rsp_assigned_handle != '0) begin
            recent_handles.insert(recent_handles.size(), rsp_assigned_handle);
            if (recent_handles.size() > 32)
               recent_handles.delete(0);
         end
         draw = calm ? 0 : $urandom_range(0, 6);
         stall_left <= draw;
         rsp_stall  <= (draw != 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         draw = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
         stall_left <= draw;
         rsp_stall  <= (draw != 0);
      end
   end

   task automatic send_op(
      input logic [OP_BITS-1:0]     op,
      input logic [COUNT_BITS-1:0]  count,
      input logic [COUNT_BITS-1:0]  limit,
      input logic [HANDLE_BITS-1:0] handle
   );
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_count     <= count;
      req_limit     <= limit;
      req_handle    <= handle;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_due != 0);
   endtask

   task automatic load_tokens(input logic [COUNT_BITS-1:0] value);
      drain_replies();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [COUNT_BITS-1:0] random_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return '0;
      if (pick < 62) return $urandom_range(1, 8);
      if (pick < 75) return $urandom_range(9, 64);
      if (pick < 88) return $urandom();
      return ALL_ONES - $urandom_range(0, 15);
   endfunction

   task automatic random_item();
      int                     pick;
      logic [OP_BITS-1:0]     op;
      logic [COUNT_BITS-1:0]  limit;
      logic [HANDLE_BITS-1:0] handle;
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_REQUEST;
      else if (pick < 47) op = OP_TRY_REQUEST;
      else if (pick < 67) op = OP_RELEASE;
      else if (pick < 82) op = OP_ADD_LIMIT;
      else if (pick < 97) op = OP_CANCEL;
      else                op = OP_BITS'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
      pick = $urandom_range(0, 9);
      if (pick < 3)      limit = '0;
      else if (pick < 8) limit = $urandom_range(1, 40);
      else               limit = $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 7 && recent_handles.size() != 0)
         handle = recent_handles[$urandom_range(0, recent_handles.size() - 1)];
      else if (pick < 8)
         handle = '0;
      else
         handle = HANDLE_BITS'($urandom());
      send_op(op, random_count(), limit, handle);
   endtask

   initial begin
      logic [COUNT_BITS-1:0] settings[7];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, pool starts empty with no waiters
      calm = 1'b0;
      send_op(OP_REQUEST, '0, '0, '0);
      send_op(OP_TRY_REQUEST, 5, '0, '0);
      send_op(OP_REQUEST, 3, '0, '0);
      send_op(OP_TRY_REQUEST, '0, '0, '0);
      send_op(OP_ADD_LIMIT, '0, 9, '0);
      send_op(OP_ADD_LIMIT, 2, 1, '0);
      send_op(OP_ADD_LIMIT, 5, 1, '0);
      send_op(OP_RELEASE, 2, '0, '0);
      send_op(OP_RELEASE, ALL_ONES, '0, '0);
      send_op(OP_RELEASE, 1, '0, '0);
      send_op(OP_REQUEST, ALL_ONES, '0, '0);
      send_op(OP_CANCEL, '0, '0, '0);
      for (int op = OP_UNKNOWN_LO; op <= OP_UNKNOWN_HI; op++)
         send_op(OP_BITS'(op), ALL_ONES, ALL_ONES, '1);
      send_op(OP_ADD_LIMIT, ALL_ONES, ALL_ONES, '0);
      send_op(OP_REQUEST, 2, '0, '0);
      send_op(OP_REQUEST, ALL_ONES, '0, '0);
      send_op(OP_CANCEL, '0, '0, HANDLE_BITS'(2));
      drain_replies();

      // fill the wait queue with handles 3 to 18, handles 1 and 2 are gone
      load_tokens('0);
      calm = 1'b1;
      repeat (QUEUE_DEPTH + 1)
         send_op(OP_REQUEST, 1, '0, '0);
      send_op(OP_TRY_REQUEST, 1, '0, '0);
      send_op(OP_CANCEL, '0, '0, HANDLE_BITS'(1));
      send_op(OP_CANCEL, '0, '0, HANDLE_BITS'(3));
      send_op(OP_CANCEL, '0, '0, HANDLE_BITS'(10));
      send_op(OP_CANCEL, '0, '0, HANDLE_BITS'(18));
      repeat (QUEUE_DEPTH - 2)
         send_op(OP_RELEASE, 1, '0, '0);

      settings[0] = '0;
      settings[1] = 12;
      settings[2] = ALL_ONES;
      settings[3] = 3;
      settings[4] = $urandom_range(0, 40);
      settings[5] = ALL_ONES - 15;
      settings[6] = $urandom();
      foreach (settings[p]) begin
         load_tokens(settings[p]);
         for (int n = 0; n < 100; n++) begin
            if (n % 25 == 0)
               calm = ($urandom_range(0, 3) == 0);
            if (n == 50 && p % 2 == 0)
               drain_replies();
            random_item();
         end
      end

      drain_replies();
      repeat (70) @(posedge clock);
      if (fail_total == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ftp_pkg.sv
src/ftp_alu.sv
src/ftp_ram.sv
src/fifo_token_pool_unit.sv
tb/pool_checker.sv
tb/testbench.sv
